[rtl/gha_pkg.sv]
`default_nettype none
package gha_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int CMD_DEPTH_DEF = 32;
  localparam int VER_W         = 16;
  localparam int ID_W          = 5;
  localparam int CMD_W         = 3;
  localparam int KIND_W        = 3;
  localparam int LIVE_W        = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE  = 3'd0,
    CMD_DESTROY = 3'd1,
    CMD_PROCESS = 3'd2,
    CMD_CHECK   = 3'd3,
    CMD_DALL    = 3'd4
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    K_CREATE_REPLY = 3'd0,
    K_CHECK_REPLY  = 3'd1,
    K_CREATE_EVT   = 3'd2,
    K_DESTROY_EVT  = 3'd3,
    K_DONE         = 3'd4,
    K_FULL         = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_C_RD, ST_C_WR, ST_T_RD, ST_T_WR,
    ST_DRAIN, ST_DR_Q, ST_DR_S, ST_SW_RD, ST_SW_CH
  } state_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [ID_W-1:0]   id;
    logic [VER_W-1:0]  ver;
    logic              ok;
    logic              last;
  } emit_t;

endpackage
`default_nettype wire

[rtl/gha_ram.sv]
`default_nettype none
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/generational_handle_allocator.sv]
`default_nettype none
// Create, destroy, check: one slot table read, then a write where the slot changes (a fresh slot is written unread).
// Process: drains the queue, reading each queued command, then its slot; destroy-all then frees every live slot in use.
// One word in work at a time; a result held in the output register stalls the next one.
// Reset (rst, synchronous) empties the free list and command queue and zeroes the counts;
// table and queue memories are not cleared and are never read before being written.
module generational_handle_allocator #(
  parameter int SLOTS     = gha_pkg::SLOTS_DEF,
  parameter int CMD_DEPTH = gha_pkg::CMD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,   // slot_id[4:0], handle_version[20:5]
  input  wire logic [2:0]  s_tuser,   // cmd[2:0]
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,   // out_slot_id[4:0], out_version[20:5], ok[21], live_count[26:22]
  output      logic [2:0]  m_tuser,   // kind[2:0]
  output      logic        m_tlast
);
  import gha_pkg::*;

  localparam int SW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int QW  = $clog2(CMD_DEPTH);
  localparam int PCW = $clog2(CMD_DEPTH + 1);
  localparam int EW  = 1 + SW + VER_W;
  localparam int TW  = VER_W + 2;

  state_t state, state_next;
  logic [CMD_W-1:0] cmd_r;
  logic [ID_W-1:0]  id_r;
  logic [VER_W-1:0] ver_r;
  logic [CW-1:0]    siu, siu_next, active, active_next, sweep, sweep_next;
  logic [SW-1:0]    fhead, fhead_next, ftail, ftail_next;
  logic             fempty, fempty_next;
  logic [QW-1:0]    phead, phead_next;
  logic [PCW-1:0]   pcount, pcount_next;

  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [TW-1:0] s_wdata, s_rdata;
  logic          n_we;
  logic [SW-1:0] n_rdata;
  logic          q_we;
  logic [QW-1:0] q_waddr;
  logic [EW-1:0] q_wdata, q_rdata;

  logic [PCW:0]  q_sum;
  logic          can_emit, in_range, hv, q_full;
  logic [SW-1:0] tidx, qidx;
  logic          dslot;
  logic [SW-1:0] didx;
  logic [VER_W-1:0] dver;
  emit_t         em;

  gha_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_slot (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));
  gha_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_next (
    .clk, .we(n_we), .waddr(ftail), .wdata(didx), .raddr(fhead), .rdata(n_rdata));
  gha_ram #(.WIDTH(EW), .DEPTH(CMD_DEPTH)) u_queue (
    .clk, .we(q_we), .waddr(q_waddr), .wdata(q_wdata), .raddr(phead), .rdata(q_rdata));

  assign s_tready = (state == ST_IDLE);
  assign can_emit = !m_tvalid || m_tready;
  assign tidx     = SW'(id_r - ID_W'(1));
  assign qidx     = q_rdata[VER_W +: SW];
  assign in_range = (id_r != '0) && (id_r <= ID_W'(SLOTS)) && (id_r <= ID_W'(siu));
  assign hv       = s_rdata[0] && !s_rdata[1] && (s_rdata[TW-1:2] == ver_r);
  assign q_full   = (pcount >= PCW'(CMD_DEPTH));
  assign q_sum    = (PCW+1)'(phead) + (PCW+1)'(pcount);
  assign q_waddr  = (q_sum >= (PCW+1)'(CMD_DEPTH)) ? QW'(q_sum - (PCW+1)'(CMD_DEPTH))
                                                    : QW'(q_sum);

  always_comb begin
    unique case (state)
      ST_C_RD, ST_C_WR:   s_raddr = fhead;
      ST_DR_Q, ST_DR_S:   s_raddr = qidx;
      ST_SW_RD, ST_SW_CH: s_raddr = SW'(sweep);
      default:            s_raddr = tidx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      siu    <= '0;
      fhead  <= '0;
      ftail  <= '0;
      fempty <= 1'b1;
      active <= '0;
      phead  <= '0;
      pcount <= '0;
      sweep  <= '0;
    end else begin
      state  <= state_next;
      siu    <= siu_next;
      fhead  <= fhead_next;
      ftail  <= ftail_next;
      fempty <= fempty_next;
      active <= active_next;
      phead  <= phead_next;
      pcount <= pcount_next;
      sweep  <= sweep_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_r <= s_tuser;
      id_r  <= s_tdata[ID_W-1:0];
      ver_r <= s_tdata[ID_W +: VER_W];
    end
  end

  always_comb begin
    state_next  = state;
    siu_next    = siu;
    fhead_next  = fhead;
    ftail_next  = ftail;
    fempty_next = fempty;
    active_next = active;
    phead_next  = phead;
    pcount_next = pcount;
    sweep_next  = sweep;
    s_we    = 1'b0;
    s_waddr = tidx;
    s_wdata = s_rdata;
    n_we    = 1'b0;
    q_we    = 1'b0;
    q_wdata = {1'b0, tidx, ver_r};
    dslot   = 1'b0;
    didx    = qidx;
    dver    = s_rdata[TW-1:2];
    em      = '{valid: 1'b0, kind: K_DONE, id: '0, ver: '0, ok: 1'b0, last: 1'b0};

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority case (cmd_r)
          CMD_CREATE: begin
            if (q_full || (fempty && siu == CW'(SLOTS))) begin
              em = '{1'b1, K_FULL, '0, '0, 1'b0, 1'b1};
              if (can_emit) state_next = ST_IDLE;
            end else if (fempty) begin
              // fresh slot goes straight out: list stays empty
              em = '{1'b1, K_CREATE_REPLY, ID_W'(siu + CW'(1)), '0, 1'b1, 1'b1};
              if (can_emit) begin
                s_we        = 1'b1;
                s_waddr     = SW'(siu);
                s_wdata     = {{VER_W{1'b0}}, 2'b01};
                q_we        = 1'b1;
                q_wdata     = {1'b0, SW'(siu), {VER_W{1'b0}}};
                pcount_next = pcount + PCW'(1);
                siu_next    = siu + CW'(1);
                state_next  = ST_IDLE;
              end
            end else begin
              state_next = ST_C_RD;
            end
          end
          CMD_DESTROY, CMD_CHECK: begin
            if (in_range) begin
              state_next = ST_T_RD;
            end else begin
              em = '{1'b1, (cmd_r == CMD_CHECK) ? K_CHECK_REPLY : K_DONE,
                     id_r, ver_r, 1'b0, 1'b1};
              if (can_emit) state_next = ST_IDLE;
            end
          end
          CMD_PROCESS, CMD_DALL: state_next = ST_DRAIN;
          default: begin
            em = '{1'b1, K_DONE, '0, '0, 1'b0, 1'b1};
            if (can_emit) state_next = ST_IDLE;
          end
        endcase
      end
      ST_C_RD: state_next = ST_C_WR;
      ST_C_WR: begin
        em = '{1'b1, K_CREATE_REPLY, ID_W'(fhead) + ID_W'(1), s_rdata[TW-1:2], 1'b1, 1'b1};
        if (can_emit) begin
          s_we        = 1'b1;
          s_waddr     = fhead;
          s_wdata     = {s_rdata[TW-1:2], 2'b01};
          q_we        = 1'b1;
          q_wdata     = {1'b0, fhead, s_rdata[TW-1:2]};
          pcount_next = pcount + PCW'(1);
          if (fhead == ftail) fempty_next = 1'b1;
          else                fhead_next  = n_rdata;
          state_next  = ST_IDLE;
        end
      end
      ST_T_RD: state_next = ST_T_WR;
      ST_T_WR: begin
        if (cmd_r == CMD_CHECK) begin
          em = '{1'b1, K_CHECK_REPLY, id_r, ver_r, hv, 1'b1};
          if (can_emit) state_next = ST_IDLE;
        end else begin
          em = '{1'b1, K_DONE, id_r, ver_r, hv && !q_full, 1'b1};
          if (can_emit) begin
            if (hv && !q_full) begin
              s_we        = 1'b1;
              s_wdata     = {s_rdata[TW-1:2], 2'b11};
              q_we        = 1'b1;
              q_wdata     = {1'b1, tidx, ver_r};
              pcount_next = pcount + PCW'(1);
            end
            state_next = ST_IDLE;
          end
        end
      end
      ST_DRAIN: begin
        if (pcount != '0) begin
          state_next = ST_DR_Q;
        end else if (cmd_r == CMD_DALL) begin
          sweep_next = '0;
          state_next = ST_SW_RD;
        end else begin
          em = '{1'b1, K_DONE, '0, '0, 1'b1, 1'b1};
          if (can_emit) state_next = ST_IDLE;
        end
      end
      ST_DR_Q: state_next = ST_DR_S;
      ST_DR_S: begin
        if (q_rdata[EW-1]) begin
          dslot = (q_rdata[VER_W-1:0] == s_rdata[TW-1:2]) && s_rdata[0];
        end else begin
          em = '{1'b1, K_CREATE_EVT, ID_W'(qidx) + ID_W'(1), s_rdata[TW-1:2], 1'b1, 1'b0};
          if (can_emit && active != CW'(SLOTS)) active_next = active + CW'(1);
        end
        if (can_emit || !(dslot || em.valid)) begin
          phead_next  = (phead == QW'(CMD_DEPTH - 1)) ? '0 : phead + QW'(1);
          pcount_next = pcount - PCW'(1);
          state_next  = ST_DRAIN;
        end
      end
      ST_SW_RD: begin
        if (sweep >= siu) begin
          em = '{1'b1, K_DONE, '0, '0, 1'b1, 1'b1};
          if (can_emit) state_next = ST_IDLE;
        end else begin
          state_next = ST_SW_CH;
        end
      end
      ST_SW_CH: begin
        didx  = SW'(sweep);
        dslot = s_rdata[0];
        if (can_emit || !dslot) begin
          sweep_next = sweep + CW'(1);
          state_next = ST_SW_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // free a slot: bump version, append to the free list, drop the live count, emit the event
    if (dslot) begin
      em = '{1'b1, K_DESTROY_EVT, ID_W'(didx) + ID_W'(1), dver, 1'b1, 1'b0};
      if (can_emit) begin
        s_we    = 1'b1;
        s_waddr = didx;
        s_wdata = {dver + VER_W'(1), 2'b00};
        if (active != '0) active_next = active - CW'(1);
        if (fempty) begin
          fhead_next  = didx;
          fempty_next = 1'b0;
        end else begin
          n_we = 1'b1;
        end
        ftail_next = didx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_emit) begin
      m_tvalid <= em.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit && em.valid) begin
      m_tuser <= em.kind;
      m_tdata <= {5'b0, LIVE_W'(active_next), em.ok, em.ver, em.id};
      m_tlast <= em.last;
    end
  end
endmodule
`default_nettype wire
